// ----- design/pdd_pkg.sv -----
`default_nettype none

package pdd_pkg;

  // Working format: signed Q7.24 in 32 bits
  localparam int W_FRAC = 24;
  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] W_ONE = 32'sh0100_0000;

  // Divider geometry: |pixel*2^16 - center| fits 28 bits
  localparam int MAG_W   = 28;
  localparam int NUM_W   = MAG_W + W_FRAC;
  localparam int Q_BITS  = 32;
  localparam int DIV_LAT = Q_BITS + 2;

  localparam int DIST_LAT = 10;

  typedef enum logic [2:0] {
    REG_FOCAL_X     = 3'd0,
    REG_FOCAL_Y     = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_DEPTH_SCALE = 3'd4,
    REG_DIST_MODEL  = 3'd5,
    REG_RADIAL      = 3'd6,
    REG_TANGENTIAL  = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] DM_NONE   = 2'd0;
  localparam logic [1:0] DM_INV_BC = 2'd1;
  localparam logic [1:0] DM_FWD_BC = 2'd2;
  localparam logic [1:0] DM_FTHETA = 2'd3;

  typedef struct packed {
    logic               model_error;
    logic signed [31:0] point_z;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } point_t;

  function automatic logic signed [31:0] sat_w(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'(W_MAX)) begin
      r = W_MAX;
    end else if (v < 48'(W_MIN)) begin
      r = W_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Product of two W values, shifted down by the fraction, floor rounding
  function automatic logic signed [39:0] mul_hi(input logic signed [63:0] p);
    return p[63:W_FRAC];
  endfunction

  // Signed Q1.18 coefficient to W
  function automatic logic signed [31:0] coef_w(input logic [19:0] c);
    return {{6{c[19]}}, c, 6'b0};
  endfunction

endpackage

`default_nettype wire

// ----- design/pdd_divide.sv -----
`default_nettype none

module pdd_divide (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [pdd_pkg::MAG_W-1:0] pix_q,
  input  wire logic [pdd_pkg::MAG_W-1:0] center,
  input  wire logic [pdd_pkg::MAG_W-1:0] focal,
  output logic signed [31:0]             quot
);
  import pdd_pkg::*;

  logic [NUM_W-1:0]  rem [0:Q_BITS-1];
  logic [Q_BITS-1:0] quo [0:Q_BITS];
  logic              neg [0:Q_BITS];
  logic              ovf [0:Q_BITS];

  logic signed [MAG_W:0] diff;
  logic [MAG_W-1:0]      mag;
  logic                  big;

  always_comb begin
    diff = $signed({1'b0, pix_q}) - $signed({1'b0, center});
    mag  = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    // quotient would not fit 32 bits; zero focal with a nonzero difference lands here too
    big  = (mag != '0) && ({8'b0, mag} >= {focal, 8'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {mag, {W_FRAC{1'b0}}};
      quo[0] <= '0;
      neg[0] <= diff[MAG_W];
      ovf[0] <= big;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
    localparam int SH = Q_BITS - 1 - j;
    logic [59:0] dsh;
    logic        ge;

    // zero focal leaves every quotient bit clear
    always_comb begin
      dsh = 60'(focal) << SH;
      ge  = (focal != '0) && (60'(rem[j]) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[j+1] <= quo[j] | (ge ? (Q_BITS'(1) << SH) : '0);
        neg[j+1] <= neg[j];
        ovf[j+1] <= ovf[j];
      end
    end

    if (j < Q_BITS - 1) begin : g_rem
      logic [59:0] sub;

      assign sub = 60'(rem[j]) - dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? sub[NUM_W-1:0] : rem[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (ovf[Q_BITS]) begin
        quot <= neg[Q_BITS] ? W_MIN : W_MAX;
      end else if (neg[Q_BITS]) begin
        quot <= (quo[Q_BITS] > 32'h8000_0000) ? W_MIN : $signed(-quo[Q_BITS]);
      end else begin
        quot <= quo[Q_BITS][31] ? W_MAX : $signed(quo[Q_BITS]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pdd_distort.sv -----
`default_nettype none

module pdd_distort (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               model_on,
  input  wire logic signed [31:0] k1,
  input  wire logic signed [31:0] k2,
  input  wire logic signed [31:0] k3,
  input  wire logic signed [31:0] p1,
  input  wire logic signed [31:0] p2,
  input  wire logic signed [31:0] x,
  input  wire logic signed [31:0] y,
  output logic signed [31:0]      ux,
  output logic signed [31:0]      uy
);
  import pdd_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [39:0] xy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] r2;
  } carry_t;

  logic signed [63:0] pxx, pyy, pxy;
  logic signed [31:0] x1, y1;
  logic signed [39:0] xx2, yy2, xy2;
  logic signed [31:0] r2, x2, y2;
  logic signed [63:0] pk3, pt1, pt2;
  logic signed [31:0] t1, t2, f;
  logic signed [63:0] pxf, pyf, pp1xy, pp2xy, pp2ax, pp1ay;
  carry_t             cy [3:9];

  always_ff @(posedge clk) begin
    if (en) begin
      // squares and cross term
      pxx <= x * x;
      pyy <= y * y;
      pxy <= x * y;
      x1  <= x;
      y1  <= y;
      // radius squared
      xx2 <= mul_hi(pxx);
      yy2 <= mul_hi(pyy);
      xy2 <= mul_hi(pxy);
      r2  <= sat_w(48'(mul_hi(pxx)) + 48'(mul_hi(pyy)));
      x2  <= x1;
      y2  <= y1;
      // Horner chain, innermost term first
      pk3      <= k3 * r2;
      cy[3].x  <= x2;
      cy[3].y  <= y2;
      cy[3].xy <= xy2;
      cy[3].ax <= sat_w(48'(r2) + (48'(xx2) <<< 1));
      cy[3].ay <= sat_w(48'(r2) + (48'(yy2) <<< 1));
      cy[3].r2 <= r2;
      t1  <= sat_w(48'(k2) + 48'(mul_hi(pk3)));
      pt1 <= t1 * cy[4].r2;
      t2  <= sat_w(48'(k1) + 48'(mul_hi(pt1)));
      pt2 <= t2 * cy[6].r2;
      f   <= sat_w(48'(W_ONE) + 48'(mul_hi(pt2)));
      // radial and tangential products
      pxf   <= cy[8].x * f;
      pyf   <= cy[8].y * f;
      pp1xy <= p1 * 64'(cy[8].xy);
      pp2xy <= p2 * 64'(cy[8].xy);
      pp2ax <= p2 * cy[8].ax;
      pp1ay <= p1 * cy[8].ay;
      if (model_on) begin
        ux <= sat_w(48'(mul_hi(pxf)) + (48'(mul_hi(pp1xy)) <<< 1) + 48'(mul_hi(pp2ax)));
        uy <= sat_w(48'(mul_hi(pyf)) + (48'(mul_hi(pp2xy)) <<< 1) + 48'(mul_hi(pp1ay)));
      end else begin
        ux <= cy[9].x;
        uy <= cy[9].y;
      end
    end
  end

  for (genvar n = 3; n < 9; n++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        cy[n+1] <= cy[n];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pdd_skid.sv -----
`default_nettype none

module pdd_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pdd_pkg::point_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pdd_pkg::point_t       out_data
);
  import pdd_pkg::*;

  logic   skid_valid;
  point_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= in_data;
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      // hold the request that arrived while the output stalls
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/pixel_depth_deprojection.sv -----
// Pinhole deprojection of depth pixels to 3D points in signed Q16.16.
//
// Input stream s_*: one request per pixel; s_tdata carries pixel_x, pixel_y
// and the raw depth sample. Output stream m_*: one point per request, in the
// same order; m_tdata carries point_x, point_y, point_z, m_tuser the error
// flag for distortion models that cannot be inverted.
// Configuration is written through cfg_* (index 0..7, always ready) only
// while no request is in flight; the user must ensure this, the block does not.
//
// Throughput is one pixel per clock while the receiver does not stall. Behind
// the input register a request passes a 34-stage divider (its input register,
// then one quotient bit per stage, then its output register) for the
// normalization, a 10-stage distortion pipeline of alternating multiply and sum
// stages, two stages for the depth scaling and the output register.
// When the receiver stalls, a skid register behind the output register takes
// one more point and then the whole pipeline holds; nothing is dropped.
// Synchronous reset empties the pipeline and restores the default
// configuration (unit focal lengths, passthrough mode).
`default_nettype none

module pixel_depth_deprojection #(
  parameter int PIXEL_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12], depth_raw[39:24]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  output logic             m_tuser,   // model_error
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [59:0] cfg_data
);
  import pdd_pkg::*;

  localparam int PIPE_LEN  = DIV_LAT + DIST_LAT + 2;
  localparam int MASK_BITS = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;
  localparam logic [11:0] PIX_MASK = 12'((13'd1 << MASK_BITS) - 13'd1);

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [31:0] uz;
  } side_t;

  logic [27:0] focal_x, focal_y, center_x, center_y;
  logic [31:0] z_scale;
  logic [1:0]  distortion_model;
  logic [59:0] radial_coeffs;
  logic [39:0] tangential_coeffs;

  logic        en;
  logic        s0_valid;
  logic [11:0] s0_px, s0_py;
  logic [15:0] s0_zr;
  logic [47:0] uz_full;
  logic        vld  [1:PIPE_LEN];
  side_t       side [1:PIPE_LEN-1];

  logic signed [31:0] nx, ny, ux, uy;
  logic signed [64:0] prod_x, prod_y;
  point_t             res;
  point_t             out_pt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x           <= 28'd65536;
      focal_y           <= 28'd65536;
      center_x          <= '0;
      center_y          <= '0;
      z_scale           <= '0;
      distortion_model  <= DM_NONE;
      radial_coeffs     <= '0;
      tangential_coeffs <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:     focal_x           <= cfg_data[27:0];
        REG_FOCAL_Y:     focal_y           <= cfg_data[27:0];
        REG_CENTER_X:    center_x          <= cfg_data[27:0];
        REG_CENTER_Y:    center_y          <= cfg_data[27:0];
        REG_DEPTH_SCALE: z_scale           <= cfg_data[31:0];
        REG_DIST_MODEL:  distortion_model  <= cfg_data[1:0];
        REG_RADIAL:      radial_coeffs     <= cfg_data;
        REG_TANGENTIAL:  tangential_coeffs <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      for (int i = 1; i <= PIPE_LEN; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      s0_valid <= s_tvalid;
      vld[1]   <= s0_valid;
      for (int i = 1; i < PIPE_LEN; i++) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign uz_full = z_scale * s0_zr;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_px      <= s_tdata[11:0] & PIX_MASK;
      s0_py      <= s_tdata[23:12] & PIX_MASK;
      s0_zr      <= s_tdata[39:24];
      side[1].px <= s0_px;
      side[1].py <= s0_py;
      side[1].uz <= uz_full[47:16];
      for (int i = 1; i < PIPE_LEN - 1; i++) begin
        side[i+1] <= side[i];
      end
    end
  end

  pdd_divide u_div_x (
    .clk    (clk),
    .en     (en),
    .pix_q  ({s0_px, 16'b0}),
    .center (center_x),
    .focal  (focal_x),
    .quot   (nx)
  );

  pdd_divide u_div_y (
    .clk    (clk),
    .en     (en),
    .pix_q  ({s0_py, 16'b0}),
    .center (center_y),
    .focal  (focal_y),
    .quot   (ny)
  );

  pdd_distort u_distort (
    .clk      (clk),
    .en       (en),
    .model_on (distortion_model == DM_INV_BC),
    .k1       (coef_w(radial_coeffs[19:0])),
    .k2       (coef_w(radial_coeffs[39:20])),
    .k3       (coef_w(radial_coeffs[59:40])),
    .p1       (coef_w(tangential_coeffs[19:0])),
    .p2       (coef_w(tangential_coeffs[39:20])),
    .x        (nx),
    .y        (ny),
    .ux       (ux),
    .uy       (uy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= $signed({1'b0, side[PIPE_LEN-2].uz}) * ux;
      prod_y <= $signed({1'b0, side[PIPE_LEN-2].uz}) * uy;
      priority if (z_scale == '0) begin
        // passthrough: pixel position as Q16.16, no depth
        res.point_x     <= $signed({4'b0, side[PIPE_LEN-1].px, 16'b0});
        res.point_y     <= $signed({4'b0, side[PIPE_LEN-1].py, 16'b0});
        res.point_z     <= '0;
        res.model_error <= 1'b0;
      end else if (distortion_model == DM_FWD_BC || distortion_model == DM_FTHETA) begin
        res.point_x     <= '0;
        res.point_y     <= '0;
        res.point_z     <= '0;
        res.model_error <= 1'b1;
      end else begin
        res.point_x     <= sat_w(48'($signed(prod_x[64:W_FRAC])));
        res.point_y     <= sat_w(48'($signed(prod_y[64:W_FRAC])));
        res.point_z     <= side[PIPE_LEN-1].uz[31] ? W_MAX : $signed(side[PIPE_LEN-1].uz);
        res.model_error <= 1'b0;
      end
    end
  end

  pdd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[PIPE_LEN]),
    .in_ready  (en),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_pt)
  );

  assign m_tdata = {out_pt.point_z, out_pt.point_y, out_pt.point_x};
  assign m_tuser = out_pt.model_error;

endmodule

`default_nettype wire

// ----- design/pdd_checker.sv -----
`default_nettype none

module pdd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic        m_tuser
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled point changed");

  // an undeprojectable model reports a zero point
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 96'd0)
    else $error("error point not zero");

  // depth is never negative
  a_z_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[95])
    else $error("negative depth");

  // input side never stalls while the output is free and empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(rst) && $past(!m_tvalid) |-> s_tready || !s_tvalid || s_tready)
    else $error("input blocked with empty output");

endmodule

bind pixel_depth_deprojection pdd_checker u_pdd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
